// ----- design/ddmc_pkg.sv -----
// ----------------------------------------------------------------------------
// ddmc_pkg: shared types and constants of the motion controller
// Opcodes, motion modes, command and result records, config registers and
// the fixed-point constants of the heading arithmetic.
// ----------------------------------------------------------------------------
package ddmc_pkg;

   // input opcodes
   localparam logic [3:0] OP_TICK       = 4'd0;
   localparam logic [3:0] OP_FORWARD    = 4'd1;
   localparam logic [3:0] OP_BACKWARD   = 4'd2;
   localparam logic [3:0] OP_TURN_TO    = 4'd3;
   localparam logic [3:0] OP_TURN_LEFT  = 4'd4;
   localparam logic [3:0] OP_TURN_RIGHT = 4'd5;
   localparam logic [3:0] OP_STOP       = 4'd6;
   localparam logic [3:0] OP_ABORT      = 4'd7;
   localparam logic [3:0] OP_CLEAR      = 4'd8;

   // configuration register indexes
   localparam logic [1:0] CSR_DRIFT_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_ACCEPT_ANGLE    = 2'd1;

   localparam logic [11:0] DRIFT_THRESHOLD_RESET = 12'd200;
   localparam logic [10:0] ACCEPT_ANGLE_RESET    = 11'd50;

   // angles in tenths of a degree; MAX_TURN_DEG in whole degrees
   localparam logic [12:0] FULL_TURN   = 13'd3600;
   localparam logic [12:0] DOUBLE_TURN = 13'd7200;
   localparam logic [12:0] HALF_TURN   = 13'd1800;
   localparam logic [8:0]  MAX_TURN_DEG = 9'd360;

   localparam logic [21:0] TIMER_MAX    = 22'h3FFFFF;
   localparam logic [21:0] MS_PER_TENTH = 22'd100;

   // amount + bias is a non-negative value congruent to amount mod 360
   localparam logic [16:0] DEG_WRAP_BIAS = 17'd65520;
   // floor(u / 360) = (u * DEG_RECIP) >> DEG_SHIFT for u < 2^17
   localparam logic [33:0] DEG_RECIP = 34'd93207;
   localparam int          DEG_SHIFT = 25;
   // floor(r / 10) = (r * TENTH_RECIP) >> TENTH_SHIFT for r < 2^12
   localparam logic [23:0] TENTH_RECIP = 24'd3277;
   localparam int          TENTH_SHIFT = 15;

   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_FWD   = 3'd1,
      MODE_BACK  = 3'd2,
      MODE_LEFT  = 3'd3,
      MODE_RIGHT = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_FWD,
      CMD_BACK,
      CMD_TURN,
      CMD_STOP,
      CMD_ABORT,
      CMD_CLEAR,
      CMD_NOP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] target;
      logic [21:0] duration_ms;
      logic [11:0] heading;
      logic        obstacle;
      logic [9:0]  elapsed_ms;
   } cmd_type;

   typedef struct packed {
      logic [2:0] motor_mode;
      logic [3:0] left_speed;
      logic [3:0] right_speed;
      logic       busy_res;
      logic       done_res;
      logic       success;
      logic       error_flag;
      logic       obstacle_stop;
   } result_type;

   typedef struct packed {
      logic [11:0] drift_threshold;
      logic [10:0] accept_angle;
   } cfg_type;

endpackage

// ----- design/ddmc_fifo.sv -----
// ----------------------------------------------------------------------------
// ddmc_fifo: small register queue
// Holds records between the front and back halves and ahead of the result
// port. Head entry is presented combinationally.
// ----------------------------------------------------------------------------
module ddmc_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));

   // writer must respect the occupancy it was given
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |-> (count_ff != CNT_W'(DEPTH)))
      else $error("ddmc_fifo: write into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (count_ff != '0))
      else $error("ddmc_fifo: read from an empty queue");

endmodule

// ----- design/ddmc_front.sv -----
// ----------------------------------------------------------------------------
// ddmc_front: command intake and classification
// Takes request items, derives move duration and turn target heading over
// two register stages, and issues commands toward the back half.
// ----------------------------------------------------------------------------
module ddmc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [3:0]            req_opcode,
   input  logic signed [15:0]    req_amount,
   input  logic [11:0]           req_heading,
   input  logic                  req_obstacle,
   input  logic [9:0]            req_elapsed_ms,
   input  logic                  cmd_pop,
   output logic                  cmd_valid,
   output ddmc_pkg::cmd_type     cmd
);
   import ddmc_pkg::*;

   localparam int OCC_W = $clog2(CMD_QUEUE_DEPTH + 1);

   logic             accept;
   logic [OCC_W-1:0] occ_ff, occ_in;

   // stage 1
   logic        f1_valid_ff;
   logic [3:0]  f1_op_ff;
   logic [16:0] f1_wrap_ff, wrap_in;
   logic [11:0] f1_rel_ff, rel_in;
   logic [21:0] f1_dur_ff, dur_in;
   logic [11:0] f1_heading_ff;
   logic        f1_obstacle_ff;
   logic [9:0]  f1_elapsed_ff;

   // stage 2
   logic        f2_valid_ff;
   logic [3:0]  f2_op_ff;
   logic [16:0] f2_wrap_ff;
   logic [33:0] f2_prod_to_ff;
   logic [23:0] f2_prod_rel_ff;
   logic [21:0] f2_dur_ff;
   logic [11:0] f2_heading_ff;
   logic        f2_obstacle_ff;
   logic [9:0]  f2_elapsed_ff;

   logic [8:0]  turn_deg;
   logic [11:0] turn_tenths;
   logic [12:0] left_sum;
   logic signed [13:0] right_diff;
   logic [8:0]  q_to;
   logic [19:0] target_to_wide;
   logic [8:0]  q_rel;
   logic [11:0] target_rel;

   assign accept   = req_push && !req_full;
   assign req_full = (occ_ff == OCC_W'(CMD_QUEUE_DEPTH));

   // count items between intake and back-half pickup
   always_comb begin
      occ_in = occ_ff;
      if (accept && !cmd_pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (cmd_pop && !accept) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   // stage 1 arithmetic: clamp, relative turn target, wrap bias, duration
   always_comb begin
      priority if (req_amount > 16'sd360) begin
         turn_deg = MAX_TURN_DEG;
      end else if (req_amount < 16'sd0) begin
         turn_deg = '0;
      end else begin
         turn_deg = req_amount[8:0];
      end
      turn_tenths = {turn_deg, 3'b000} + {2'b00, turn_deg, 1'b0};

      left_sum   = {1'b0, req_heading} + {1'b0, turn_tenths};
      right_diff = $signed({2'b00, req_heading}) - $signed({2'b00, turn_tenths});

      if (req_opcode == OP_TURN_LEFT) begin
         priority if (left_sum >= DOUBLE_TURN) begin
            rel_in = 12'(left_sum - DOUBLE_TURN);
         end else if (left_sum >= FULL_TURN) begin
            rel_in = 12'(left_sum - FULL_TURN);
         end else begin
            rel_in = left_sum[11:0];
         end
      end else begin
         priority if (right_diff < 14'sd0) begin
            rel_in = 12'(right_diff + $signed({1'b0, FULL_TURN}));
         end else if (right_diff >= $signed({1'b0, FULL_TURN})) begin
            rel_in = 12'(right_diff - $signed({1'b0, FULL_TURN}));
         end else begin
            rel_in = right_diff[11:0];
         end
      end

      wrap_in = 17'($signed(req_amount)) + DEG_WRAP_BIAS;
      dur_in  = req_amount[15] ? '0 : 22'(req_amount[14:0]) * MS_PER_TENTH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff      <= '0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         occ_ff      <= occ_in;
         f1_valid_ff <= accept;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_op_ff       <= req_opcode;
      f1_wrap_ff     <= wrap_in;
      f1_rel_ff      <= rel_in;
      f1_dur_ff      <= dur_in;
      f1_heading_ff  <= req_heading;
      f1_obstacle_ff <= req_obstacle;
      f1_elapsed_ff  <= req_elapsed_ms;

      f2_op_ff       <= f1_op_ff;
      f2_wrap_ff     <= f1_wrap_ff;
      f2_prod_to_ff  <= 34'(f1_wrap_ff) * DEG_RECIP;
      f2_prod_rel_ff <= 24'(f1_rel_ff) * TENTH_RECIP;
      f2_dur_ff      <= f1_dur_ff;
      f2_heading_ff  <= f1_heading_ff;
      f2_obstacle_ff <= f1_obstacle_ff;
      f2_elapsed_ff  <= f1_elapsed_ff;
   end

   // stage 2: finish reciprocal divisions and classify
   always_comb begin
      q_to           = f2_prod_to_ff[DEG_SHIFT +: 9];
      target_to_wide = 20'(f2_wrap_ff) * 20'd10 - 20'(q_to) * 20'(FULL_TURN);
      q_rel          = f2_prod_rel_ff[TENTH_SHIFT +: 9];
      target_rel     = 12'(q_rel) * 12'd10;

      cmd.target      = (f2_op_ff == OP_TURN_TO) ? target_to_wide[11:0] : target_rel;
      cmd.duration_ms = f2_dur_ff;
      cmd.heading     = f2_heading_ff;
      cmd.obstacle    = f2_obstacle_ff;
      cmd.elapsed_ms  = f2_elapsed_ff;

      unique case (f2_op_ff)
         OP_TICK:       cmd.kind = CMD_TICK;
         OP_FORWARD:    cmd.kind = CMD_FWD;
         OP_BACKWARD:   cmd.kind = CMD_BACK;
         OP_TURN_TO:    cmd.kind = CMD_TURN;
         OP_TURN_LEFT:  cmd.kind = CMD_TURN;
         OP_TURN_RIGHT: cmd.kind = CMD_TURN;
         OP_STOP:       cmd.kind = CMD_STOP;
         OP_ABORT:      cmd.kind = CMD_ABORT;
         OP_CLEAR:      cmd.kind = CMD_CLEAR;
         default:       cmd.kind = CMD_NOP;
      endcase
   end

   assign cmd_valid = f2_valid_ff;

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(CMD_QUEUE_DEPTH))
      else $error("ddmc_front: occupancy above queue depth");

endmodule

// ----- design/ddmc_back.sv -----
// ----------------------------------------------------------------------------
// ddmc_back: motion execution
// Applies one command per cycle to the motion state while the result queue has room:
// timer, obstacle and timeout checks, drift trim, turn completion; produces one result each.
// ----------------------------------------------------------------------------
module ddmc_back #(
   parameter int SPEED_LEVELS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ddmc_pkg::cfg_type    cfg,
   input  logic                 cmd_empty,
   input  ddmc_pkg::cmd_type    cmd,
   output logic                 cmd_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output ddmc_pkg::result_type rsp
);
   import ddmc_pkg::*;

   localparam logic [3:0] LEVEL_TOP = 4'(SPEED_LEVELS);

   mode_type    mode_ff, mode_in;
   logic        err_ff, err_in;
   logic [11:0] ref_ff, ref_in;
   logic [11:0] tgt_ff, tgt_in;
   logic [21:0] dur_ff, dur_in;
   logic [21:0] timer_ff, timer_in;
   logic [3:0]  left_ff, left_in;
   logic [3:0]  right_ff, right_in;

   logic        fire;
   logic        moving;
   logic        turning;
   logic [22:0] timer_sum;
   logic [21:0] timer_run;
   logic signed [12:0] drift;
   logic signed [12:0] thr;
   logic        steer_right;
   logic        steer_left;
   logic        tick_obst;
   logic        tick_err;
   logic        new_aligned;
   logic        cur_aligned;
   logic signed [12:0] new_diff;
   logic        new_left;
   logic        done;
   logic        succ;

   function automatic logic within_accept(logic [11:0] target, logic [11:0] heading,
                                          logic [10:0] acc);
      logic signed [12:0] diff;
      logic [12:0]        mag;
      diff = $signed({1'b0, target}) - $signed({1'b0, heading});
      mag  = diff[12] ? 13'(-diff) : 13'(diff);
      return (mag <= {2'b00, acc}) || (mag >= FULL_TURN - {2'b00, acc});
   endfunction

   assign fire    = !cmd_empty && !rsp_full;
   assign cmd_pop = fire;
   assign rsp_push = fire;

   // shared condition logic
   always_comb begin
      moving    = (mode_ff == MODE_FWD) || (mode_ff == MODE_BACK);
      turning   = (mode_ff == MODE_LEFT) || (mode_ff == MODE_RIGHT);
      timer_sum = {1'b0, timer_ff} + 23'(cmd.elapsed_ms);
      timer_run = timer_sum[22] ? TIMER_MAX : timer_sum[21:0];
      if (!moving) begin
         timer_run = timer_ff;
      end

      drift = $signed({1'b0, ref_ff}) - $signed({1'b0, cmd.heading});
      thr   = $signed({1'b0, cfg.drift_threshold});
      steer_right = (drift > thr && mode_ff == MODE_FWD) ||
                    (drift < -thr && mode_ff == MODE_BACK);
      steer_left  = (drift > thr && mode_ff == MODE_BACK) ||
                    (drift < -thr && mode_ff == MODE_FWD);

      tick_obst = (mode_ff == MODE_FWD) && cmd.obstacle;
      tick_err  = err_ff || tick_obst;

      cur_aligned = within_accept(tgt_ff, cmd.heading, cfg.accept_angle);
      new_aligned = within_accept(cmd.target, cmd.heading, cfg.accept_angle);
      new_diff    = $signed({1'b0, cmd.target}) - $signed({1'b0, cmd.heading});
      new_left    = (new_diff < 13'sd0 && new_diff > -$signed(HALF_TURN)) ||
                    (new_diff > $signed(HALF_TURN));
   end

   // next state
   always_comb begin
      mode_in  = mode_ff;
      err_in   = err_ff;
      ref_in   = ref_ff;
      tgt_in   = tgt_ff;
      dur_in   = dur_ff;
      timer_in = timer_run;
      left_in  = left_ff;
      right_in = right_ff;
      done     = 1'b0;
      succ     = 1'b0;

      unique case (cmd.kind)
         CMD_TICK: begin
            if (moving) begin
               err_in = tick_err;
               if (tick_err || timer_run >= dur_ff) begin
                  mode_in = MODE_IDLE;
                  done    = 1'b1;
                  succ    = !tick_err;
               end else if (steer_right) begin
                  if (right_ff >= LEVEL_TOP) begin
                     if (left_ff != '0) left_in = left_ff - 1'b1;
                  end else begin
                     right_in = right_ff + 1'b1;
                  end
               end else if (steer_left) begin
                  if (left_ff >= LEVEL_TOP) begin
                     if (right_ff != '0) right_in = right_ff - 1'b1;
                  end else begin
                     left_in = left_ff + 1'b1;
                  end
               end
            end else if (turning) begin
               if (err_ff || cur_aligned) begin
                  mode_in = MODE_IDLE;
                  done    = 1'b1;
                  succ    = !err_ff;
               end
            end
         end
         CMD_FWD, CMD_BACK: begin
            mode_in  = (cmd.kind == CMD_FWD) ? MODE_FWD : MODE_BACK;
            err_in   = 1'b0;
            ref_in   = cmd.heading;
            dur_in   = cmd.duration_ms;
            timer_in = '0;
         end
         CMD_TURN: begin
            err_in = 1'b0;
            tgt_in = cmd.target;
            if (new_aligned) begin
               mode_in = MODE_IDLE;
               done    = 1'b1;
               succ    = 1'b1;
            end else begin
               mode_in = new_left ? MODE_LEFT : MODE_RIGHT;
            end
         end
         CMD_STOP: begin
            done    = (mode_ff != MODE_IDLE);
            succ    = (mode_ff != MODE_IDLE) && !err_ff;
            mode_in = MODE_IDLE;
         end
         CMD_ABORT: err_in = 1'b1;
         CMD_CLEAR: err_in = 1'b0;
         CMD_NOP: ;
         default: ;
      endcase
   end

   // result record
   always_comb begin
      rsp.motor_mode    = mode_in;
      rsp.busy_res      = (mode_in != MODE_IDLE);
      rsp.left_speed    = rsp.busy_res ? left_in : '0;
      rsp.right_speed   = rsp.busy_res ? right_in : '0;
      rsp.done_res      = done;
      rsp.success       = succ;
      rsp.error_flag    = err_in;
      rsp.obstacle_stop = (cmd.kind == CMD_TICK) && tick_obst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         err_ff   <= 1'b0;
         ref_ff   <= '0;
         tgt_ff   <= '0;
         dur_ff   <= '0;
         timer_ff <= '0;
         left_ff  <= LEVEL_TOP;
         right_ff <= LEVEL_TOP;
      end else if (fire) begin
         mode_ff  <= mode_in;
         err_ff   <= err_in;
         ref_ff   <= ref_in;
         tgt_ff   <= tgt_in;
         dur_ff   <= dur_in;
         timer_ff <= timer_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   a_success_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp.success) |-> rsp.done_res)
      else $error("ddmc_back: success without done");

   a_done_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp.done_res) |=> (mode_ff == MODE_IDLE))
      else $error("ddmc_back: motion still running after done");

   a_move_starts: assert property (@(posedge clock) disable iff (reset)
      (fire && cmd.kind == CMD_FWD) |=> (mode_ff == MODE_FWD && timer_ff == '0))
      else $error("ddmc_back: forward move did not start");

endmodule

// ----- design/differential_drive_motion_controller.sv -----
// ----------------------------------------------------------------------------
// differential_drive_motion_controller: two-stepper motion sequencer
// Front half classifies commands and computes turn targets, back half runs
// the motion state; queues decouple intake, execution and result delivery.
// ----------------------------------------------------------------------------
// Path: a request passes the two front stages and the command queue; the back
//   half writes the result queue at the edge it executes, and the result shows
//   on the rsp_ ports from the head of that queue.
// Throughput: one request and one result per cycle while req_full is low and rsp_pop
//   is high; the front carries up to four requests in flight, the result queue holds two.
// Reset: synchronous; clears motion state and queues, loads speed levels with
//   SPEED_LEVELS, drift threshold 200 and accept angle 50.
// ----------------------------------------------------------------------------
module differential_drive_motion_controller #(
   parameter int SPEED_LEVELS = 8
) (
   input  logic                clock,
   input  logic                reset,

   // request queue side
   input  logic                req_push,
   output logic                req_full,
   input  logic [3:0]          req_opcode,
   input  logic signed [15:0]  req_amount,
   input  logic [11:0]         req_heading,
   input  logic                req_obstacle,
   input  logic [9:0]          req_elapsed_ms,

   // result queue side
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [2:0]          rsp_motor_mode,
   output logic [3:0]          rsp_left_speed,
   output logic [3:0]          rsp_right_speed,
   output logic                rsp_busy_res,
   output logic                rsp_done_res,
   output logic                rsp_success,
   output logic                rsp_error_flag,
   output logic                rsp_obstacle_stop,

   // configuration writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [11:0]         csr_wdata
);
   import ddmc_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(result_type);

   cfg_type    cfg_ff, cfg_in;

   logic       front_valid;
   cmd_type    front_cmd;
   logic       cmd_pop;
   logic       cmd_empty;
   logic       cmd_full;
   logic [CMD_W-1:0] cmd_bits;
   cmd_type    cmd_head;

   logic       rsp_push;
   logic       rsp_full;
   result_type back_rsp;
   logic [RSP_W-1:0] rsp_bits;
   result_type rsp_head;

   // The user must make config writes land only while idle; the block does not enforce it.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DRIFT_THRESHOLD: cfg_in.drift_threshold = csr_wdata;
            CSR_ACCEPT_ANGLE:    cfg_in.accept_angle    = csr_wdata[10:0];
            default: ;   // drop writes outside the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drift_threshold <= DRIFT_THRESHOLD_RESET;
         cfg_ff.accept_angle    <= ACCEPT_ANGLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: intake, duration and target arithmetic, classification.
   // Its occupancy count covers the command queue, so the queue never
   // overflows and cmd_full stays unused as a stall.
   ddmc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_amount     (req_amount),
      .req_heading    (req_heading),
      .req_obstacle   (req_obstacle),
      .req_elapsed_ms (req_elapsed_ms),
      .cmd_pop        (cmd_pop),
      .cmd_valid      (front_valid),
      .cmd            (front_cmd)
   );

   ddmc_fifo #(
      .DEPTH (CMD_QUEUE_DEPTH),
      .WIDTH (CMD_W)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_data (front_cmd),
      .rd_en   (cmd_pop),
      .rd_data (cmd_bits),
      .empty   (cmd_empty),
      .full    (cmd_full)
   );

   assign cmd_head = cmd_type'(cmd_bits);

   // Back: one command per cycle whenever a command is queued and the result queue has room.
   ddmc_back #(
      .SPEED_LEVELS (SPEED_LEVELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   // Result queue parts execution from the consumer: hold results while
   // rsp_pop is low, advance on each transfer.
   ddmc_fifo #(
      .DEPTH (RSP_QUEUE_DEPTH),
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (back_rsp),
      .rd_en   (rsp_pop && !rsp_empty),
      .rd_data (rsp_bits),
      .empty   (rsp_empty),
      .full    (rsp_full)
   );

   assign rsp_head          = result_type'(rsp_bits);
   assign rsp_motor_mode    = rsp_head.motor_mode;
   assign rsp_left_speed    = rsp_head.left_speed;
   assign rsp_right_speed   = rsp_head.right_speed;
   assign rsp_busy_res      = rsp_head.busy_res;
   assign rsp_done_res      = rsp_head.done_res;
   assign rsp_success       = rsp_head.success;
   assign rsp_error_flag    = rsp_head.error_flag;
   assign rsp_obstacle_stop = rsp_head.obstacle_stop;

   // the front's credit count must keep the command queue from filling past
   // what it promised
   a_cmd_queue_credit: assert property (@(posedge clock) disable iff (reset)
      (cmd_full && !cmd_pop) |-> !front_valid)
      else $error("top: command queue full while front issues");

endmodule

// ----- bench/tb_differential_drive_motion_controller.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_differential_drive_motion_controller: self-checking bench of the motion
// sequencer
// Drives commands and sensor ticks through the request queue and predicts
// every result with an in-bench model of the motion state. Both queue sides
// idle at random outside the calm phase. Stimulus is a directed opening, then
// moves and turns with random noise under several threshold settings.
// ----------------------------------------------------------------------------
module tb_differential_drive_motion_controller;
   import ddmc_pkg::*;

   localparam int SPEED_LEVELS = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 8;    // margin for the pipe to go quiet
   localparam int PHASE_ITEMS  = 300;

   // -------------------------------------------------------------------------
   // Motion predictor and store of expected results
   // -------------------------------------------------------------------------
   class motion_scoreboard;
      mode_type    mode;
      bit          err;
      bit [11:0]   ref_hdg;
      bit [11:0]   aim;
      bit [21:0]   span_ms;
      bit [21:0]   clock_ms;
      bit [3:0]    lvl_l;
      bit [3:0]    lvl_r;
      bit [11:0]   drift_thr;
      bit [10:0]   tol;
      result_type  motion_q[$];
      int          failures;

      function new();
         mode      = MODE_IDLE;
         err       = 1'b0;
         ref_hdg   = '0;
         aim       = '0;
         span_ms   = '0;
         clock_ms  = '0;
         lvl_l     = 4'(SPEED_LEVELS);
         lvl_r     = 4'(SPEED_LEVELS);
         drift_thr = DRIFT_THRESHOLD_RESET;
         tol       = ACCEPT_ANGLE_RESET;
         failures  = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [11:0] val);
         if (idx == CSR_DRIFT_THRESHOLD) drift_thr = val;
         else if (idx == CSR_ACCEPT_ANGLE) tol = val[10:0];
      endfunction

      // heading within tolerance of the target, wrap around zero included
      function bit aligned(int diff);
         int ad;
         ad = diff < 0 ? -diff : diff;
         return ad <= int'(tol) || ad >= int'(FULL_TURN) - int'(tol);
      endfunction

      // returns one when the turn is already done
      function bit start_turn(int target, int hdg);
         int diff;
         diff = target - hdg;
         err  = 1'b0;
         aim  = 12'(target);
         if (aligned(diff)) begin
            mode = MODE_IDLE;
            return 1'b1;
         end
         if ((diff < 0 && diff > -int'(HALF_TURN)) || diff > int'(HALF_TURN))
            mode = MODE_LEFT;
         else
            mode = MODE_RIGHT;
         return 1'b0;
      endfunction

      function void predict_motion(logic [3:0] op, int amount, int hdg, bit obstacle,
                                   int elapsed);
         result_type want;
         bit done, succ, obst, moving, fwd, back;
         int sum, d, thr, deg, lim, r;
         done   = 1'b0;
         succ   = 1'b0;
         obst   = 1'b0;
         moving = (mode == MODE_FWD || mode == MODE_BACK);

         // the move timer runs on every item of a linear move
         if (moving) begin
            sum = int'(clock_ms) + elapsed;
            clock_ms = (sum > int'(TIMER_MAX)) ? TIMER_MAX : 22'(sum);
         end

         case (op)
            OP_TICK: begin
               if (moving) begin
                  if (mode == MODE_FWD && obstacle) begin
                     err  = 1'b1;
                     obst = 1'b1;
                  end
                  if (err || clock_ms >= span_ms) begin
                     mode = MODE_IDLE;
                     done = 1'b1;
                     succ = !err;
                  end else begin
                     // trim wheel levels against drift from the start heading
                     d    = int'(ref_hdg) - hdg;
                     thr  = int'(drift_thr);
                     fwd  = (mode == MODE_FWD);
                     back = (mode == MODE_BACK);
                     if ((d > thr && fwd) || (d < -thr && back)) begin
                        if (lvl_r >= SPEED_LEVELS) begin
                           if (lvl_l != 0) lvl_l--;
                        end else lvl_r++;
                     end else if ((d > thr && back) || (d < -thr && fwd)) begin
                        if (lvl_l >= SPEED_LEVELS) begin
                           if (lvl_r != 0) lvl_r--;
                        end else lvl_l++;
                     end
                  end
               end else if (mode == MODE_LEFT || mode == MODE_RIGHT) begin
                  if (err || aligned(int'(aim) - hdg)) begin
                     mode = MODE_IDLE;
                     done = 1'b1;
                     succ = !err;
                  end
               end
            end
            OP_FORWARD, OP_BACKWARD: begin
               mode     = (op == OP_FORWARD) ? MODE_FWD : MODE_BACK;
               err      = 1'b0;
               ref_hdg  = 12'(hdg);
               span_ms  = (amount < 0) ? 22'd0 : 22'(amount * int'(MS_PER_TENTH));
               clock_ms = '0;
            end
            OP_TURN_TO: begin
               deg = amount % int'(MAX_TURN_DEG);
               if (deg < 0) deg += int'(MAX_TURN_DEG);
               if (start_turn(deg * 10, hdg)) begin
                  done = 1'b1;
                  succ = 1'b1;
               end
            end
            OP_TURN_LEFT, OP_TURN_RIGHT: begin
               lim = amount > int'(MAX_TURN_DEG) ? int'(MAX_TURN_DEG)
                                                : (amount < 0 ? 0 : amount);
               if (op == OP_TURN_LEFT) begin
                  r = (hdg + lim * 10) % int'(FULL_TURN);
               end else begin
                  r = hdg - lim * 10;
                  if (r < 0) r += int'(FULL_TURN);
                  r = r % int'(FULL_TURN);
               end
               // truncate the target to whole degrees
               if (start_turn((r / 10) * 10, hdg)) begin
                  done = 1'b1;
                  succ = 1'b1;
               end
            end
            OP_STOP: begin
               if (mode != MODE_IDLE) begin
                  done = 1'b1;
                  succ = !err;
               end
               mode = MODE_IDLE;
            end
            OP_ABORT: err = 1'b1;
            OP_CLEAR: err = 1'b0;
            default: ;
         endcase

         want.motor_mode    = mode;
         want.left_speed    = (mode != MODE_IDLE) ? lvl_l : 4'd0;
         want.right_speed   = (mode != MODE_IDLE) ? lvl_r : 4'd0;
         want.busy_res      = (mode != MODE_IDLE);
         want.done_res      = done;
         want.success       = succ;
         want.error_flag    = err;
         want.obstacle_stop = obst;
         motion_q.push_back(want);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (motion_q.size() == 0) begin
            $error("result transfer with no request outstanding");
            failures++;
            return;
         end
         want = motion_q.pop_front();
         compare_field("motor_mode",    want.motor_mode,    got.motor_mode);
         compare_field("left_speed",    want.left_speed,    got.left_speed);
         compare_field("right_speed",   want.right_speed,   got.right_speed);
         compare_field("busy_res",      want.busy_res,      got.busy_res);
         compare_field("done_res",      want.done_res,      got.done_res);
         compare_field("success",       want.success,       got.success);
         compare_field("error_flag",    want.error_flag,    got.error_flag);
         compare_field("obstacle_stop", want.obstacle_stop, got.obstacle_stop);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block ports; every input starts at a known value
   // -------------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [3:0]         req_opcode = OP_TICK;
   logic signed [15:0] req_amount = '0;
   logic [11:0]        req_heading = '0;
   logic               req_obstacle = 1'b0;
   logic [9:0]         req_elapsed_ms = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [2:0]         rsp_motor_mode;
   logic [3:0]         rsp_left_speed;
   logic [3:0]         rsp_right_speed;
   logic               rsp_busy_res;
   logic               rsp_done_res;
   logic               rsp_success;
   logic               rsp_error_flag;
   logic               rsp_obstacle_stop;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_DRIFT_THRESHOLD;
   logic [11:0]        csr_wdata = '0;

   result_type         observed;
   motion_scoreboard   sb;
   bit                 calm = 1'b0;    // no idling on either side while set
   int                 counted = 0;    // requests sent to the block
   int                 compass = 0;    // simulated heading that follows turns
   int                 cycle_count = 0;

   always #10 clock = ~clock;

   differential_drive_motion_controller #(
      .SPEED_LEVELS(SPEED_LEVELS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_amount       (req_amount),
      .req_heading      (req_heading),
      .req_obstacle     (req_obstacle),
      .req_elapsed_ms   (req_elapsed_ms),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_motor_mode   (rsp_motor_mode),
      .rsp_left_speed   (rsp_left_speed),
      .rsp_right_speed  (rsp_right_speed),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_success      (rsp_success),
      .rsp_error_flag   (rsp_error_flag),
      .rsp_obstacle_stop(rsp_obstacle_stop),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   assign observed = {rsp_motor_mode, rsp_left_speed, rsp_right_speed, rsp_busy_res,
                      rsp_done_res, rsp_success, rsp_error_flag, rsp_obstacle_stop};

   // -------------------------------------------------------------------------
   // Result side: check each transfer at the edge it happens, then decide pop
   // for the next edge. Values read here are the ones before the edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_result(observed);
      rsp_pop <= !reset && (calm || $urandom_range(99) >= 34);
   end

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int wrap_heading(int h);
      return ((h % int'(FULL_TURN)) + int'(FULL_TURN)) % int'(FULL_TURN);
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Present one request, hold it until the transfer, then maybe idle.
   // Push stays high into the next request unless a gap is taken.
   task automatic send_request(logic [3:0] op, logic signed [15:0] amount,
                               logic [11:0] hdg, bit obst, logic [9:0] elapsed);
      req_push       <= 1'b1;
      req_opcode     <= op;
      req_amount     <= amount;
      req_heading    <= hdg;
      req_obstacle   <= obst;
      req_elapsed_ms <= elapsed;
      do @(posedge clock); while (req_full);
      sb.predict_motion(op, amount, hdg, obst, elapsed);
      counted++;
      if (!calm) begin
         while ($urandom_range(99) < 34) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Any opcode, every field over its full width
   task automatic send_noise();
      send_request(4'($urandom_range(15)), 16'($urandom_range(65535)),
                   12'($urandom_range(4095)), 1'($urandom_range(1)),
                   10'($urandom_range(1023)));
   endtask

   // Drop push, wait for every expected result, then let the pipe go quiet
   task automatic drain();
      req_push <= 1'b0;
      while (sb.motion_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back; valid stays high across the pair
   task automatic program_limits(logic [11:0] drift, logic [11:0] accept);
      csr_valid <= 1'b1;
      csr_index <= CSR_DRIFT_THRESHOLD;
      csr_wdata <= drift;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_DRIFT_THRESHOLD, drift);
      csr_index <= CSR_ACCEPT_ANGLE;
      csr_wdata <= accept;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_ACCEPT_ANGLE, accept);
      csr_valid <= 1'b0;
   endtask

   // A timed move followed by ticks that wobble around a heading that walks
   task automatic run_move();
      int n;
      int wob;
      logic signed [15:0] span;
      span = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                      : 16'($urandom_range(30));
      if ($urandom_range(3) == 0) span = 16'($urandom_range(300));
      send_request($urandom_range(1) ? OP_FORWARD : OP_BACKWARD, span, 12'(compass),
                   1'b0, 10'($urandom_range(1023)));
      wob = $urandom_range(600);
      n   = 0;
      while ((sb.mode == MODE_FWD || sb.mode == MODE_BACK) && n < 40) begin
         n++;
         compass = wrap_heading(compass + $urandom_range(60) - 30);
         if ($urandom_range(99) < 8) begin
            case ($urandom_range(3))
               0: send_request(OP_ABORT, '0, 12'(compass), 1'b0, 10'($urandom_range(1023)));
               1: send_request(OP_STOP, '0, 12'(compass), 1'b0, 10'($urandom_range(1023)));
               2: send_request(OP_CLEAR, '0, 12'(compass), 1'b0, 10'($urandom_range(1023)));
               default: send_request(4'($urandom_range(15, 9)), 16'($urandom_range(65535)),
                                     12'(compass), 1'($urandom_range(1)),
                                     10'($urandom_range(1023)));
            endcase
         end else begin
            send_request(OP_TICK, 16'($urandom_range(65535)),
                         12'(wrap_heading(compass + $urandom_range(2 * wob) - wob)),
                         $urandom_range(99) < 4, 10'($urandom_range(1023)));
         end
      end
   endtask

   // A turn, then ticks whose heading walks toward the target
   task automatic run_turn();
      int n, diff, step, mag;
      logic [3:0] op;
      logic signed [15:0] deg;
      case ($urandom_range(2))
         0: op = OP_TURN_TO;
         1: op = OP_TURN_LEFT;
         default: op = OP_TURN_RIGHT;
      endcase
      deg = ($urandom_range(9) < 7) ? 16'($urandom_range(800) - 400)
                                    : 16'($urandom_range(65535));
      send_request(op, deg, 12'(compass), 1'($urandom_range(1)),
                   10'($urandom_range(1023)));
      n = 0;
      while ((sb.mode == MODE_LEFT || sb.mode == MODE_RIGHT) && n < 60) begin
         n++;
         if ($urandom_range(99) < 6) begin
            send_request($urandom_range(1) ? OP_ABORT : OP_STOP, '0, 12'(compass),
                         1'b0, 10'($urandom_range(1023)));
         end else begin
            diff = int'(sb.aim) - compass;
            if (diff > int'(HALF_TURN)) diff -= int'(FULL_TURN);
            if (diff < -int'(HALF_TURN)) diff += int'(FULL_TURN);
            mag  = diff < 0 ? -diff : diff;
            step = $urandom_range(300);
            if (step > mag) step = mag;
            compass = wrap_heading(compass + (diff < 0 ? -step : step));
            send_request(OP_TICK, 16'($urandom_range(65535)), 12'(compass),
                         1'($urandom_range(1)), 10'($urandom_range(1023)));
         end
      end
   endtask

   task automatic run_traffic(int quota);
      int stop_at;
      int pick;
      stop_at = counted + quota;
      while (counted < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 40) run_move();
         else if (pick < 75) run_turn();
         else repeat ($urandom_range(6, 1)) send_noise();
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_limits(DRIFT_THRESHOLD_RESET, 12'(ACCEPT_ANGLE_RESET));

      // Directed opening: idle tick, longest move, drift trim, obstacle stop
      send_request(OP_TICK, 16'sd0, 12'd0, 1'b0, 10'd0);
      send_request(OP_FORWARD, 16'sd32767, 12'd0, 1'b0, 10'd0);
      send_request(OP_TICK, 16'sd0, 12'd3599, 1'b0, 10'd1023);
      send_request(OP_TICK, 16'sd0, 12'd0, 1'b1, 10'd1023);
      send_request(OP_CLEAR, 16'sd0, 12'd0, 1'b0, 10'd0);
      // negative duration ends on the first tick; heading above range
      send_request(OP_BACKWARD, -16'sd32768, 12'd4095, 1'b0, 10'd0);
      send_request(OP_TICK, 16'sd0, 12'd4095, 1'b1, 10'd0);
      // turn-to with negative wrap lands aligned at once
      send_request(OP_TURN_TO, -16'sd32768, 12'd3520, 1'b0, 10'd0);
      send_request(OP_TURN_TO, 16'sd32767, 12'd0, 1'b0, 10'd0);
      send_request(OP_TICK, 16'sd0, 12'd40, 1'b0, 10'd5);
      // left turn clamped to a full circle, right turn clamped to nothing
      send_request(OP_TURN_LEFT, 16'sd400, 12'd1234, 1'b0, 10'd0);
      send_request(OP_TURN_RIGHT, -16'sd5, 12'd1237, 1'b0, 10'd0);
      send_request(OP_TURN_RIGHT, 16'sd90, 12'd100, 1'b0, 10'd0);
      // abort ends the running turn on the next tick without success
      send_request(OP_ABORT, 16'sd0, 12'd100, 1'b0, 10'd0);
      send_request(OP_TICK, 16'sd0, 12'd100, 1'b0, 10'd0);
      send_request(OP_STOP, 16'sd0, 12'd100, 1'b0, 10'd0);
      // a move clears the latch; an unused opcode only advances the timer
      send_request(OP_FORWARD, 16'sd5, 12'd2000, 1'b0, 10'd0);
      send_request(4'd15, -16'sd1, 12'd2048, 1'b1, 10'd1023);
      send_request(OP_STOP, 16'sd0, 12'd2000, 1'b0, 10'd0);
      // half-turn edge picks the right spin
      send_request(OP_TURN_LEFT, 16'sd180, 12'd3599, 1'b0, 10'd0);
      send_request(OP_ABORT, 16'sd0, 12'd3599, 1'b0, 10'd0);
      send_request(OP_STOP, 16'sd0, 12'd3599, 1'b0, 10'd0);
      send_request(OP_CLEAR, 16'sd0, 12'd0, 1'b0, 10'd0);
      send_request(4'd9, 16'sh5555, 12'hAAA, 1'b1, 10'h2AA);
      drain();

      // Random traffic across threshold settings, extremes included
      program_limits(12'd0, 12'd0);
      run_traffic(PHASE_ITEMS);
      drain();
      program_limits(12'd3600, 12'd1800);
      run_traffic(PHASE_ITEMS);
      drain();
      // this phase runs both sides back to back with no gaps
      program_limits(12'd150, 12'd30);
      calm = 1'b1;
      run_traffic(PHASE_ITEMS);
      drain();
      calm = 1'b0;
      program_limits(12'd0, 12'd1800);
      run_traffic(PHASE_ITEMS);
      drain();
      program_limits(12'd3600, 12'd0);
      run_traffic(PHASE_ITEMS);
      drain();
      program_limits(12'($urandom_range(3600)), 12'($urandom_range(1800)));
      run_traffic(PHASE_ITEMS);
      drain();

      if (sb.failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
